// ===== rtl/stlb_pkg.sv =====
// Shared definitions for the scrolling text line buffer.
// Command codes, character constants, parameter defaults and the
// controller/datapath handshake structs. No dependencies.
package stlb_pkg;

  localparam int unsigned LINES_DEF     = 20;
  localparam int unsigned ROW_SLOTS_DEF = 41;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_BKSP  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd125;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } stlb_cmd_t;

  typedef struct packed {
    logic out_free;
  } stlb_sts_t;

endpackage

// ===== rtl/stlb_ctrl.sv =====
// Sequencer for the scrolling text line buffer.
// Steps each beat through load, execute and finish; uses stlb_pkg.
module stlb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  stlb_pkg::stlb_sts_t sts_i,
  output stlb_pkg::stlb_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.finish  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/stlb_dp.sv =====
// Datapath of the scrolling text line buffer: character store, line
// length store, top pointer, bottom line length and output register.
// Driven by stlb_ctrl through stlb_pkg structs.
module stlb_dp #(
  parameter int unsigned LINES     = stlb_pkg::LINES_DEF,
  parameter int unsigned ROW_SLOTS = stlb_pkg::ROW_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stlb_pkg::stlb_cmd_t cmd_i,
  output stlb_pkg::stlb_sts_t sts_o,
  input  logic [1:0]          command_i,
  input  logic [7:0]          char_code_i,
  input  logic [4:0]          read_line_i,
  input  logic [5:0]          read_col_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [6:0]          read_char_o,
  output logic                backspace_done_o,
  output logic [5:0]          cursor_column_o
);

  localparam int unsigned CAP    = ROW_SLOTS - 1;
  localparam int unsigned LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned LEN_W  = $clog2(ROW_SLOTS);
  localparam int unsigned COL_W  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned DEPTH  = LINES << COL_W;

  logic [1:0]        cmd_q;
  logic [7:0]        code_q;
  logic [4:0]        rline_q;
  logic [5:0]        col_q;

  logic [LINE_W-1:0] top_q, top_d, bot_q, bot_d;
  logic [LEN_W-1:0]  cur_q, cur_d;
  logic [LINES-1:0]  lvalid_q;
  logic              done_q;

  logic [LEN_W-1:0]  len_mem [LINES];
  logic [6:0]        char_mem [DEPTH];

  logic [6:0]        char_rd_q;
  logic [LEN_W-1:0]  len_rd_q;
  logic              lv_q, bot_hit_q, in_rng_q;

  logic              ov_q;
  logic [6:0]        rchar_q;
  logic              bs_q;
  logic [5:0]        cursor_q;

  logic              is_print, is_lf, put_ok, scroll, in_rng;
  logic [LEN_W-1:0]  cur_inc, scroll_len, line_len;
  logic [LINE_W-1:0] top_inc, rl, p;
  logic [LINE_W:0]   psum;
  logic              hit;
  logic [6:0]        rchar_d;

  // command decode
  assign is_print = (code_q >= stlb_pkg::CHAR_SPACE) && (code_q <= stlb_pkg::CHAR_LAST);
  assign is_lf    = (code_q == stlb_pkg::CHAR_LF);
  assign cur_inc  = cur_q + LEN_W'(1);
  assign put_ok   = cmd_i.exec && (cmd_q == stlb_pkg::CMD_PUT) && is_print;
  assign scroll   = cmd_i.exec && (cmd_q == stlb_pkg::CMD_PUT)
                    && (is_lf || (is_print && (cur_inc == LEN_W'(CAP))));
  assign scroll_len = is_lf ? cur_q : cur_inc;
  assign top_inc  = (top_q == LINE_W'(LINES - 1)) ? '0 : top_q + LINE_W'(1);

  // display line to physical line
  assign in_rng = ({2'b00, rline_q} < 7'(LINES));
  assign rl     = in_rng ? LINE_W'(rline_q) : '0;
  assign psum   = {1'b0, top_q} + {1'b0, rl};
  assign p      = (psum >= (LINE_W + 1)'(LINES)) ? LINE_W'(psum - (LINE_W + 1)'(LINES))
                                                  : LINE_W'(psum);

  always_comb begin
    cur_d = cur_q;
    top_d = top_q;
    bot_d = bot_q;
    if (cmd_i.exec) begin
      case (cmd_q)
        stlb_pkg::CMD_PUT: begin
          if (scroll) begin
            cur_d = '0;
            top_d = top_inc;
            bot_d = top_q;
          end else if (put_ok) begin
            cur_d = cur_inc;
          end
        end
        stlb_pkg::CMD_BKSP: begin
          if (cur_q != '0) begin
            cur_d = cur_q - LEN_W'(1);
          end
        end
        stlb_pkg::CMD_CLEAR: begin
          cur_d = '0;
        end
        default: begin
          cur_d = cur_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= command_i;
      code_q  <= char_code_i;
      rline_q <= read_line_i;
      col_q   <= read_col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '0;
      bot_q    <= LINE_W'(LINES - 1);
      cur_q    <= '0;
      lvalid_q <= '0;
      done_q   <= 1'b0;
    end else begin
      top_q <= top_d;
      bot_q <= bot_d;
      cur_q <= cur_d;
      if (cmd_i.exec) begin
        done_q <= (cmd_q == stlb_pkg::CMD_BKSP) && (cur_q != '0);
      end
      if (cmd_i.exec && (cmd_q == stlb_pkg::CMD_CLEAR)) begin
        lvalid_q <= '0;
      end else if (scroll) begin
        lvalid_q[bot_q] <= 1'b1;
      end
    end
  end

  // line length store
  always_ff @(posedge clk_i) begin
    if (scroll) begin
      len_mem[bot_q] <= scroll_len;
    end
    if (cmd_i.exec) begin
      len_rd_q <= len_mem[p];
    end
  end

  // character store
  always_ff @(posedge clk_i) begin
    if (put_ok) begin
      char_mem[{bot_q, cur_q[COL_W-1:0]}] <= code_q[6:0];
    end
    if (cmd_i.exec) begin
      char_rd_q <= char_mem[{p, COL_W'(col_q)}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      lv_q      <= lvalid_q[p];
      bot_hit_q <= (p == bot_q);
      in_rng_q  <= in_rng;
    end
  end

  assign line_len = bot_hit_q ? cur_q : (lv_q ? len_rd_q : '0);
  assign hit      = in_rng_q && (cmd_q == stlb_pkg::CMD_READ)
                    && (9'(col_q) < 9'(line_len)) && (9'(col_q) < 9'(CAP));
  assign rchar_d  = hit ? char_rd_q : 7'd0;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.finish) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rchar_q  <= rchar_d;
      bs_q     <= done_q;
      cursor_q <= 6'(cur_q);
    end
  end

  assign sts_o.out_free   = !ov_q || !out_stall_i;
  assign out_valid_o      = ov_q;
  assign read_char_o      = rchar_q;
  assign backspace_done_o = bs_q;
  assign cursor_column_o  = cursor_q;

endmodule

// ===== rtl/scrolling_text_line_buffer_unit.sv =====
// Top level of the scrolling text line buffer.
// Joins stlb_ctrl and stlb_dp; uses stlb_pkg.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  command, char_code, read_line, read_col
//   out      source     out_valid_o / out_stall_i read_char, backspace_done, cursor_column
//
// Each beat steps through load, one store access and result to the output
// register; no new beat is taken until the last has left the finish step.
// Scrolling moves a top pointer, so no characters are copied.
// Reset needs no clearing pass; a clear command drops all line lengths at once.
// A stalled output holds the next beat in the finish step until the register frees.
module scrolling_text_line_buffer_unit #(
  parameter int unsigned LINES     = stlb_pkg::LINES_DEF,
  parameter int unsigned ROW_SLOTS = stlb_pkg::ROW_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] char_code_i,
  input  logic [4:0] read_line_i,
  input  logic [5:0] read_col_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] read_char_o,
  output logic       backspace_done_o,
  output logic [5:0] cursor_column_o
);

  stlb_pkg::stlb_cmd_t cmd;
  stlb_pkg::stlb_sts_t sts;

  stlb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stlb_dp #(
    .LINES     (LINES),
    .ROW_SLOTS (ROW_SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .command_i        (command_i),
    .char_code_i      (char_code_i),
    .read_line_i      (read_line_i),
    .read_col_i       (read_col_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_char_o      (read_char_o),
    .backspace_done_o (backspace_done_o),
    .cursor_column_o  (cursor_column_o)
  );

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken twice in a row");

  a_bs_no_char : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && backspace_done_o) |-> (read_char_o == 7'd0))
    else $error("backspace beat carries a character");

  a_bottom_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(cursor_column_o) < int'(ROW_SLOTS - 1)) || (ROW_SLOTS > 65))
    else $error("bottom line left full");

  a_finish_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || !out_stall_i))
    else $error("result overwrites a stalled beat");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for scrolling_text_line_buffer_unit: directed and random console
// commands, with results checked against a built-in model of the line store.
// Depends on rtl/stlb_pkg.sv and rtl/scrolling_text_line_buffer_unit.sv.
`timescale 1ns / 1ps

module tb;

  localparam int ROWS = int'(stlb_pkg::LINES_DEF);
  localparam int LINE_CAP = int'(stlb_pkg::ROW_SLOTS_DEF) - 1;
  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1650;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [4:0] row;
    logic [5:0] col;
    logic       hold;
  } console_cmd_t;

  typedef struct packed {
    logic [6:0] rchar;
    logic       done;
    logic [5:0] cursor;
  } console_view_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] command_i = stlb_pkg::CMD_PUT;
  logic [7:0] char_code_i = 8'd0;
  logic [4:0] read_line_i = 5'd0;
  logic [5:0] read_col_i = 6'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [6:0] read_char_o;
  logic       backspace_done_o;
  logic [5:0] cursor_column_o;

  console_cmd_t  cmd_backlog[$];
  console_view_t awaited_views[$];
  console_cmd_t  live_cmd;
  console_view_t head_view;
  logic          hold_next = 1'b0;

  logic [6:0]  glyphs [ROWS][LINE_CAP];
  logic [5:0]  line_len [ROWS];
  int unsigned top_row;

  int send_gap = 0;
  int send_calm = 0;
  int recv_wait = 0;
  int recv_calm = 0;
  int quiet_cycles = 0;
  int views_seen = 0;
  int errors = 0;

  scrolling_text_line_buffer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .char_code_i     (char_code_i),
    .read_line_i     (read_line_i),
    .read_col_i      (read_col_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_char_o     (read_char_o),
    .backspace_done_o(backspace_done_o),
    .cursor_column_o (cursor_column_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned bottom_row();
    return (top_row + ROWS - 1) % ROWS;
  endfunction

  function automatic void roll_up();
    top_row = (top_row + 1) % ROWS;
    line_len[bottom_row()] = '0;
  endfunction

  function automatic console_view_t console_step(console_cmd_t c);
    console_view_t v;
    int unsigned row;
    v = '0;
    case (c.cmd)
      stlb_pkg::CMD_PUT: begin
        if (c.ch == stlb_pkg::CHAR_LF) begin
          roll_up();
        end else if (c.ch >= stlb_pkg::CHAR_SPACE && c.ch <= stlb_pkg::CHAR_LAST) begin
          row = bottom_row();
          if (line_len[row] >= LINE_CAP) line_len[row] = '0;
          glyphs[row][line_len[row]] = c.ch[6:0];
          line_len[row] = line_len[row] + 6'd1;
          if (line_len[row] >= LINE_CAP) roll_up();
        end
      end
      stlb_pkg::CMD_BKSP: begin
        row = bottom_row();
        if (line_len[row] != 0) begin
          line_len[row] = line_len[row] - 6'd1;
          v.done = 1'b1;
        end
      end
      stlb_pkg::CMD_CLEAR: begin
        for (int i = 0; i < ROWS; i++) line_len[i] = '0;
      end
      default: begin
        if (c.row < ROWS) begin
          row = (top_row + c.row) % ROWS;
          if (c.col < line_len[row] && c.col < LINE_CAP) v.rchar = glyphs[row][c.col];
        end
      end
    endcase
    v.cursor = line_len[bottom_row()];
    return v;
  endfunction

  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = int'($urandom_range(10, 50));
    return int'($urandom_range(0, 7));
  endfunction

  task automatic add_cmd(input logic [1:0] c, input logic [7:0] ch, input logic [4:0] r,
                         input logic [5:0] col);
    console_cmd_t e;
    e.cmd = c;
    e.ch = ch;
    e.row = r;
    e.col = col;
    e.hold = hold_next;
    hold_next = 1'b0;
    cmd_backlog.push_back(e);
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch on result %0d: %s got %0d, expected %0d", views_seen, what, got, want);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      command_i <= stlb_pkg::CMD_PUT;
      char_code_i <= 8'd0;
      read_line_i <= 5'd0;
      read_col_i <= 6'd0;
    end else begin
      if (in_valid_i && !in_stall_o) awaited_views.push_back(console_step(live_cmd));
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].hold && awaited_views.size() != 0)) begin
          live_cmd = cmd_backlog.pop_front();
          command_i <= live_cmd.cmd;
          char_code_i <= live_cmd.ch;
          read_line_i <= live_cmd.row;
          read_col_i <= live_cmd.col;
          in_valid_i <= 1'b1;
          send_gap = pick_wait(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        views_seen++;
        if (awaited_views.size() == 0) begin
          flag_mismatch("result with nothing awaited, count", 1, 0);
        end else begin
          head_view = awaited_views.pop_front();
          if (read_char_o !== head_view.rchar)
            flag_mismatch("read_char", int'(read_char_o), int'(head_view.rchar));
          if (backspace_done_o !== head_view.done)
            flag_mismatch("backspace_done", int'(backspace_done_o), int'(head_view.done));
          if (cursor_column_o !== head_view.cursor)
            flag_mismatch("cursor_column", int'(cursor_column_o), int'(head_view.cursor));
        end
        recv_wait = pick_wait(recv_calm);
      end
      out_stall_i <= (recv_wait > 0);
      if (recv_wait > 0) recv_wait--;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    int kind;
    int n;
    bit mid_hold_done;
    mid_hold_done = 1'b0;
    top_row = 0;
    for (int i = 0; i < ROWS; i++) line_len[i] = '0;

    // empty line: read past end, backspace with nothing to remove
    add_cmd(stlb_pkg::CMD_READ, 8'd0, 5'(ROWS - 1), 6'd0);
    add_cmd(stlb_pkg::CMD_BKSP, 8'hff, 5'd31, 6'd63);
    // dropped bytes
    add_cmd(stlb_pkg::CMD_PUT, 8'd0, 5'd0, 6'd0);
    add_cmd(stlb_pkg::CMD_PUT, CHAR_CR, 5'd0, 6'd0);
    add_cmd(stlb_pkg::CMD_PUT, 8'd31, 5'd0, 6'd0);
    add_cmd(stlb_pkg::CMD_PUT, 8'd126, 5'd0, 6'd0);
    add_cmd(stlb_pkg::CMD_PUT, 8'd255, 5'd31, 6'd63);
    // printable extremes
    add_cmd(stlb_pkg::CMD_PUT, stlb_pkg::CHAR_SPACE, 5'd0, 6'd0);
    add_cmd(stlb_pkg::CMD_PUT, stlb_pkg::CHAR_LAST, 5'd0, 6'd0);
    add_cmd(stlb_pkg::CMD_PUT, 8'd65, 5'd0, 6'd0);
    for (int i = 0; i < 4; i++) add_cmd(stlb_pkg::CMD_READ, 8'd0, 5'(ROWS - 1), 6'(i));
    add_cmd(stlb_pkg::CMD_BKSP, 8'd0, 5'd0, 6'd0);
    add_cmd(stlb_pkg::CMD_PUT, stlb_pkg::CHAR_LF, 5'd0, 6'd0);
    add_cmd(stlb_pkg::CMD_READ, 8'd0, 5'(ROWS - 2), 6'd1);
    // lines out of range, column past the end, then a clear
    add_cmd(stlb_pkg::CMD_READ, 8'd0, 5'd31, 6'd0);
    add_cmd(stlb_pkg::CMD_READ, 8'd0, 5'(ROWS), 6'd0);
    add_cmd(stlb_pkg::CMD_READ, 8'hff, 5'd0, 6'd63);
    add_cmd(stlb_pkg::CMD_CLEAR, 8'hff, 5'd31, 6'd63);
    add_cmd(stlb_pkg::CMD_READ, 8'd0, 5'(ROWS - 2), 6'd0);

    hold_next = 1'b1;
    while (cmd_backlog.size() < RANDOM_BEATS) begin
      if (!mid_hold_done && cmd_backlog.size() > RANDOM_BEATS / 2) begin
        hold_next = 1'b1;
        mid_hold_done = 1'b1;
      end
      kind = int'($urandom_range(0, 99));
      if (kind < 40) begin
        n = int'($urandom_range(1, LINE_CAP + 5));
        repeat (n)
          add_cmd(stlb_pkg::CMD_PUT,
                  8'($urandom_range(stlb_pkg::CHAR_SPACE, stlb_pkg::CHAR_LAST)),
                  5'($urandom), 6'($urandom));
        if ($urandom_range(0, 9) < 3)
          add_cmd(stlb_pkg::CMD_PUT, stlb_pkg::CHAR_LF, 5'($urandom), 6'($urandom));
      end else if (kind < 55) begin
        n = int'($urandom_range(1, 6));
        repeat (n) add_cmd(stlb_pkg::CMD_BKSP, 8'($urandom), 5'($urandom), 6'($urandom));
      end else if (kind < 80) begin
        n = int'($urandom_range(1, 8));
        repeat (n)
          add_cmd(stlb_pkg::CMD_READ, 8'($urandom),
                  ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(0, ROWS - 1)),
                  ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, LINE_CAP - 1)));
      end else if (kind < 82) begin
        add_cmd(stlb_pkg::CMD_CLEAR, 8'($urandom), 5'($urandom), 6'($urandom));
      end else if (kind < 92) begin
        n = int'($urandom_range(1, 4));
        repeat (n) add_cmd(2'($urandom), 8'($urandom), 5'($urandom), 6'($urandom));
      end else begin
        n = int'($urandom_range(1, 3));
        repeat (n) add_cmd(stlb_pkg::CMD_PUT, stlb_pkg::CHAR_LF, 5'($urandom), 6'($urandom));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (cmd_backlog.size() != 0 || in_valid_i || awaited_views.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && awaited_views.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
